[rtl/core/clen_pkg.sv]
// ----------------------------------------------------------------------------
// clen_pkg
// Shared character codes and helpers for the content-length deframer.
// ----------------------------------------------------------------------------
package clen_pkg;

    typedef logic [7:0] t_char;

    // line and field delimiters, digit and letter bounds, case offset
    localparam t_char CH_LF    = 8'h0A;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_COLON = 8'h3A;
    localparam t_char CH_SP    = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_VT    = 8'h0B;
    localparam t_char CH_FF    = 8'h0C;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_UC_A  = 8'h41;
    localparam t_char CH_UC_Z  = 8'h5A;
    localparam t_char CASE_OFS = 8'h20;

    // header name, lowercase
    localparam int unsigned KEY_LEN = 14;
    localparam int unsigned POS_W   = 4;

    function automatic t_char key_char(input logic [POS_W-1:0] pos);
        t_char ch;
        unique case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input t_char c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_char to_lower(input t_char c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? t_char'(c + CASE_OFS) : c;
    endfunction

endpackage

[rtl/core/clen_hdr_parse.sv]
// ----------------------------------------------------------------------------
// clen_hdr_parse
// Header line parser: finds content-length values and the end of headers.
// ----------------------------------------------------------------------------
module clen_hdr_parse
    import clen_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_char                   i_char,
    output logic                    o_body_start,
    output logic [LENGTH_WIDTH-1:0] o_body_len
);

    typedef enum logic [2:0] {
        PH_NAME,
        PH_IGNORE,
        PH_SPACE,
        PH_DIGITS,
        PH_TAIL,
        PH_BAD
    } t_phase;

    localparam int unsigned WIDE_W = LENGTH_WIDTH + 4;

    t_phase                  r_phase,    n_phase;
    logic [POS_W-1:0]        r_name_pos, n_name_pos;
    logic                    r_name_ok,  n_name_ok;
    logic                    r_not_empty, n_not_empty;
    logic [LENGTH_WIDTH-1:0] r_msg_len,  n_msg_len;
    logic [LENGTH_WIDTH-1:0] r_acc,      n_acc;

    logic [WIDE_W-1:0]       acc_x10;
    logic                    end_hdr;
    logic                    start;
    t_char                   lc;

    // accumulator times ten plus digit, with headroom to detect overflow
    always_comb begin
        acc_x10 = (WIDE_W'(r_acc) << 3) + (WIDE_W'(r_acc) << 1)
                + WIDE_W'(i_char - CH_ZERO);
    end

    assign lc = to_lower(i_char);

    // next header state for one byte
    always_comb begin
        n_phase     = r_phase;
        n_name_pos  = r_name_pos;
        n_name_ok   = r_name_ok;
        n_not_empty = r_not_empty;
        n_msg_len   = r_msg_len;
        n_acc       = r_acc;
        end_hdr     = 1'b0;
        start       = 1'b0;
        if (i_char == CH_LF) begin
            end_hdr = ((r_phase == PH_NAME) && !r_not_empty) ||
                      (r_phase == PH_SPACE) || (r_phase == PH_BAD);
            if ((r_phase == PH_DIGITS) || (r_phase == PH_TAIL)) begin
                n_msg_len = r_acc;
            end
            if (end_hdr && (r_msg_len != '0)) begin
                start     = 1'b1;
                n_msg_len = '0;
            end
            // fresh line
            n_phase     = PH_NAME;
            n_name_pos  = '0;
            n_name_ok   = 1'b1;
            n_not_empty = 1'b0;
            n_acc       = '0;
        end else begin
            unique case (r_phase)
                PH_NAME: begin
                    if (i_char != CH_CR) begin
                        n_not_empty = 1'b1;
                    end
                    if (i_char == CH_COLON) begin
                        n_phase = (r_name_ok && (r_name_pos == POS_W'(KEY_LEN)))
                                ? PH_SPACE : PH_IGNORE;
                    end else if ((r_name_pos < POS_W'(KEY_LEN)) &&
                                 (lc == key_char(r_name_pos))) begin
                        n_name_pos = r_name_pos + 1'b1;
                    end else begin
                        n_name_ok = 1'b0;
                    end
                end
                PH_SPACE, PH_DIGITS: begin
                    if (is_digit(i_char)) begin
                        // accumulator is still zero when the first digit arrives
                        n_phase = PH_DIGITS;
                        if (acc_x10[WIDE_W-1:LENGTH_WIDTH] != '0) begin
                            n_phase = PH_BAD;
                        end else begin
                            n_acc = acc_x10[LENGTH_WIDTH-1:0];
                        end
                    end else if (r_phase == PH_DIGITS) begin
                        n_phase = PH_TAIL;
                    end else if (!is_space(i_char)) begin
                        n_phase = PH_BAD;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // header state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NAME;
            r_name_pos  <= '0;
            r_name_ok   <= 1'b1;
            r_not_empty <= 1'b0;
            r_msg_len   <= '0;
            r_acc       <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_name_pos  <= n_name_pos;
            r_name_ok   <= n_name_ok;
            r_not_empty <= n_not_empty;
            r_msg_len   <= n_msg_len;
            r_acc       <= n_acc;
        end
    end

    assign o_body_start = i_en && start;
    assign o_body_len   = r_msg_len;

endmodule

[rtl/core/content_length_deframer.sv]
// ----------------------------------------------------------------------------
// content_length_deframer
// Cuts a raw byte stream into message bodies framed by content-length headers.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, while o_stall is low. Each byte
// passes an input register, then one pass of header-parse or body-count
// logic fills the result register. Header bytes give no item; each body
// byte gives one item, the last byte of a body flagged. Upstream is stalled
// only when a body byte is waiting and the result register is full and
// stalled downstream. Length values wider than LENGTH_WIDTH bits are bad.
module content_length_deframer
    import clen_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_char i_data_byte,
    output logic  o_valid,
    input  logic  i_stall,
    output t_char o_payload_byte,
    output logic  o_last_byte
);

    logic                    r_s1_valid;
    t_char                   r_s1_byte;
    logic                    r_out_valid;
    t_char                   r_out_byte;
    logic                    r_out_last;
    logic                    r_in_body;
    logic [LENGTH_WIDTH-1:0] r_remain;

    logic                    out_free;
    logic                    s1_hold;
    logic                    s1_fire;
    logic                    body_fire;
    logic                    body_last;
    logic                    body_start;
    logic [LENGTH_WIDTH-1:0] body_len;

    // stage handshakes
    assign out_free  = !r_out_valid || !i_stall;
    assign s1_hold   = r_s1_valid && r_in_body && !out_free;
    assign s1_fire   = r_s1_valid && !s1_hold;
    assign body_fire = s1_fire && r_in_body;
    assign body_last = (r_remain == LENGTH_WIDTH'(1));

    // header parsing
    clen_hdr_parse #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_hdr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (s1_fire && !r_in_body),
        .i_char       (r_s1_byte),
        .o_body_start (body_start),
        .o_body_len   (body_len)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!s1_hold) begin
            r_s1_valid <= i_valid;
        end
        if (!s1_hold) begin
            r_s1_byte <= i_data_byte;
        end
    end

    // body phase and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body <= 1'b0;
            r_remain  <= '0;
        end else if (body_fire) begin
            r_remain <= r_remain - 1'b1;
            if (body_last) begin
                r_in_body <= 1'b0;
            end
        end else if (body_start) begin
            r_in_body <= 1'b1;
            r_remain  <= body_len;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= body_fire;
        end
        if (out_free && body_fire) begin
            r_out_byte <= r_s1_byte;
            r_out_last <= body_last;
        end
    end

    assign o_stall        = s1_hold;
    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_last_byte    = r_out_last;

`ifndef SYNTHESIS
    a_body_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_remain != '0))
        else $error("body phase with zero bytes remaining");

    a_last_ends_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (body_fire && body_last) |=> !r_in_body)
        else $error("body did not end after its last byte");

    a_start_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        body_start |-> (!r_in_body && (body_len != '0)))
        else $error("body start outside header phase or with zero length");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_in_body && r_out_valid && i_stall))
        else $error("upstream stalled without a blocked body byte");
`endif

endmodule
